>>> hw/rtl/salc_pkg.sv
// Package for the set-associative LRU cache tag core: constants, types, shared commands.
// Used by salc_ctrl, salc_dp and set_assoc_lru_cache_prefetch_core.
package salc_pkg;

   localparam int NumSetsDefault   = 64;
   localparam int NumWaysDefault   = 4;
   localparam int AddrWidthDefault = 48;

   localparam int CsrIdxWidth = 2;
   localparam logic [CsrIdxWidth-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SET_BITS    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_WAYS        = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PREFETCH    = 2'd3;

   localparam int CntWidth = 32;

   // controller -> datapath commands
   typedef struct packed {
      logic take_req;    // capture request, compute demand set/tag, issue RAM read
      logic demand_upd;  // demand lookup on read data, write set back
      logic pf_read;     // issue RAM read of next-line set
      logic pf_upd;      // prefetch lookup, write set back on a miss
      logic rsp_load;    // load output register
   } salc_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic demand_miss;
      logic prefetch_on;
   } salc_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DLOOK  = 5'b00010,
      ST_PREAD  = 5'b00100,
      ST_PLOOK  = 5'b01000,
      ST_RSP    = 5'b10000
   } salc_state_type;

endpackage

>>> hw/rtl/salc_ram.sv
// Generic RAM with one write port and one registered read port.
// No package dependencies.
module salc_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/salc_ctrl.sv
// Controller state machine for the cache tag core.
// Depends on salc_pkg (command, status and state types).
module salc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  salc_pkg::salc_sts_type sts,
   output salc_pkg::salc_cmd_type cmd
);
   salc_pkg::salc_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // a new request may enter while the previous result waits in the output register
   assign req_tready = (state_ff == salc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         salc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               state_in     = salc_pkg::ST_DLOOK;
            end
         end
         salc_pkg::ST_DLOOK: begin
            cmd.demand_upd = 1'b1;
            state_in = (sts.demand_miss && sts.prefetch_on) ? salc_pkg::ST_PREAD
                                                            : salc_pkg::ST_RSP;
         end
         salc_pkg::ST_PREAD: begin
            cmd.pf_read = 1'b1;
            state_in    = salc_pkg::ST_PLOOK;
         end
         salc_pkg::ST_PLOOK: begin
            cmd.pf_upd = 1'b1;
            state_in   = salc_pkg::ST_RSP;
         end
         salc_pkg::ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = salc_pkg::ST_IDLE;
            end
         end
         default: state_in = salc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> hw/rtl/salc_dp.sv
// Datapath for the cache tag core: config registers, set RAM, LRU update, counters.
// Depends on salc_pkg and salc_ram.
module salc_dp #(
   parameter int NumSets   = salc_pkg::NumSetsDefault,
   parameter int NumWays   = salc_pkg::NumWaysDefault,
   parameter int AddrWidth = salc_pkg::AddrWidthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [salc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [3:0]                       csr_data,
   input  logic                             req_cmd,
   input  logic [AddrWidth-1:0]             req_address,
   input  salc_pkg::salc_cmd_type           cmd,
   output salc_pkg::salc_sts_type           sts,
   output logic                             rsp_hit,
   output logic                             rsp_prefetch_filled,
   output logic [salc_pkg::CntWidth-1:0]    rsp_mem_reads,
   output logic [salc_pkg::CntWidth-1:0]    rsp_mem_writes,
   output logic [salc_pkg::CntWidth-1:0]    rsp_hits,
   output logic [salc_pkg::CntWidth-1:0]    rsp_misses
);
   localparam int SetIdxW  = (NumSets > 1) ? $clog2(NumSets) : 1;
   localparam int WayIdxW  = (NumWays > 1) ? $clog2(NumWays) : 1;
   localparam int RankW    = WayIdxW;
   localparam int WayCntW  = $clog2(NumWays + 1);
   localparam int EntryW   = 1 + AddrWidth + RankW;
   localparam int RowW     = NumWays * EntryW;
   localparam int CW       = salc_pkg::CntWidth;
   localparam int MaxSb    = $clog2(NumSets);

   typedef struct packed {
      logic                 valid;
      logic [AddrWidth-1:0] tag;
      logic [RankW-1:0]     rank;
   } entry_type;

   // configuration
   logic [3:0] offset_bits_ff;
   logic [2:0] set_bits_ff;
   logic [2:0] ways_ff;
   logic       prefetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 4'd6;
         set_bits_ff    <= 3'd6;
         ways_ff        <= 3'd4;
         prefetch_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            salc_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            salc_pkg::CSR_SET_BITS:    set_bits_ff    <= csr_data[2:0];
            salc_pkg::CSR_WAYS:        ways_ff        <= csr_data[2:0];
            salc_pkg::CSR_PREFETCH:    prefetch_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective geometry
   logic [2:0]         eff_sb;
   logic [WayCntW-1:0] eff_nw;
   always_comb begin
      eff_sb = (32'(set_bits_ff) > MaxSb) ? 3'(MaxSb) : set_bits_ff;
      if (ways_ff == 3'd0)                 eff_nw = WayCntW'(1);
      else if (32'(ways_ff) > NumWays)     eff_nw = WayCntW'(NumWays);
      else                                 eff_nw = WayCntW'(ways_ff);
   end

   // request capture and address split
   logic                 is_write_ff;
   logic [AddrWidth-1:0] addr_ff;
   logic [SetIdxW-1:0]   set_ff, set_in;
   logic [AddrWidth-1:0] tag_ff, tag_in;
   logic [AddrWidth-1:0] next_addr;
   logic [AddrWidth-1:0] smask;
   logic [4:0]           tshift;

   assign smask     = ~({AddrWidth{1'b1}} << eff_sb);
   assign tshift    = 5'(offset_bits_ff) + 5'(eff_sb);
   assign next_addr = addr_ff + (AddrWidth'(1) << offset_bits_ff);

   always_comb begin
      logic [AddrWidth-1:0] a;
      a      = cmd.take_req ? req_address : next_addr;
      set_in = SetIdxW'((a >> offset_bits_ff) & smask);
      tag_in = a >> tshift;
   end

   // set RAM: one row holds all ways
   logic              ram_we;
   logic [RowW-1:0]   ram_wdata, ram_rdata;

   salc_ram #(.Width(RowW), .Depth(NumSets)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (set_ff),
      .wr_data (ram_wdata),
      .rd_addr (set_in),
      .rd_data (ram_rdata)
   );

   // valid bits in flops; tag and rank valid only once written
   logic [NumWays-1:0] vbits_ff [NumSets];

   // lookup and LRU update
   entry_type          row_rd [NumWays];
   entry_type          row_wr [NumWays];
   logic               found;
   logic               do_write;
   always_comb begin
      logic [WayIdxW-1:0] hw, iw, vw, tw;
      logic               hf, inf;
      logic [RankW-1:0]   best, old_rank, cap;
      hw = '0; iw = '0; vw = '0; hf = 1'b0; inf = 1'b0; best = '0;
      cap = RankW'(eff_nw - WayCntW'(1));
      for (int v = 0; v < NumWays; v++) begin
         row_rd[v] = ram_rdata[v*EntryW +: EntryW];
         row_rd[v].valid = vbits_ff[set_ff][v];
      end
      for (int v = NumWays - 1; v >= 0; v--) begin
         if (WayCntW'(v) < eff_nw) begin
            if (row_rd[v].valid && row_rd[v].tag == tag_ff) begin
               hf = 1'b1; hw = WayIdxW'(v);
            end
            if (!row_rd[v].valid) begin
               inf = 1'b1; iw = WayIdxW'(v);
            end
         end
      end
      for (int v = 0; v < NumWays; v++) begin
         if (WayCntW'(v) < eff_nw && row_rd[v].rank >= best) begin
            best = row_rd[v].rank; vw = WayIdxW'(v);
         end
      end
      found = hf;
      tw    = hf ? hw : (inf ? iw : vw);
      // an invalid fill ages every valid way in use, up to the rank cap
      old_rank = (!hf && inf) ? {RankW{1'b1}} : row_rd[tw].rank;
      do_write = cmd.demand_upd || (cmd.pf_upd && !hf);
      for (int v = 0; v < NumWays; v++) begin
         row_wr[v] = row_rd[v];
         if (WayCntW'(v) < eff_nw && WayIdxW'(v) != tw && row_rd[v].valid &&
             (row_rd[v].rank < old_rank || (!hf && inf)) && row_rd[v].rank < cap) begin
            row_wr[v].rank = row_rd[v].rank + RankW'(1);
         end
      end
      row_wr[tw].valid = 1'b1;
      row_wr[tw].tag   = tag_ff;
      row_wr[tw].rank  = '0;
      for (int v = 0; v < NumWays; v++) begin
         ram_wdata[v*EntryW +: EntryW] = row_wr[v];
      end
   end

   assign ram_we = do_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumSets; s++) vbits_ff[s] <= '0;
      end else if (do_write) begin
         for (int v = 0; v < NumWays; v++) vbits_ff[set_ff][v] <= row_wr[v].valid;
      end
   end

   // counters
   logic [CW-1:0] reads_ff, writes_ff, hits_ff, misses_ff;
   logic          hit_ff, pf_ff;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      return (&c) ? c : c + CW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.take_req || cmd.pf_read) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      if (cmd.take_req) begin
         is_write_ff <= req_cmd;
         addr_ff     <= req_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reads_ff <= '0; writes_ff <= '0; hits_ff <= '0; misses_ff <= '0;
         hit_ff <= 1'b0; pf_ff <= 1'b0;
      end else begin
         if (cmd.demand_upd) begin
            hit_ff  <= found;
            pf_ff   <= 1'b0;
            if (is_write_ff) writes_ff <= sat_inc(writes_ff);
            if (found) hits_ff <= sat_inc(hits_ff);
            else begin
               misses_ff <= sat_inc(misses_ff);
               reads_ff  <= sat_inc(reads_ff);
            end
         end
         if (cmd.pf_upd && !found) begin
            pf_ff    <= 1'b1;
            reads_ff <= sat_inc(reads_ff);
         end
      end
   end

   assign sts.demand_miss = !found;
   assign sts.prefetch_on = prefetch_ff;

   // output register
   logic          o_hit_ff, o_pf_ff;
   logic [CW-1:0] o_reads_ff, o_writes_ff, o_hits_ff, o_misses_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         o_hit_ff    <= hit_ff;
         o_pf_ff     <= pf_ff;
         o_reads_ff  <= reads_ff;
         o_writes_ff <= writes_ff;
         o_hits_ff   <= hits_ff;
         o_misses_ff <= misses_ff;
      end
   end

   assign rsp_hit             = o_hit_ff;
   assign rsp_prefetch_filled = o_pf_ff;
   assign rsp_mem_reads       = o_reads_ff;
   assign rsp_mem_writes      = o_writes_ff;
   assign rsp_hits            = o_hits_ff;
   assign rsp_misses          = o_misses_ff;
endmodule

>>> hw/rtl/set_assoc_lru_cache_prefetch_core.sv
// Top level of the set-associative LRU cache tag core with next-line prefetch.
// Depends on salc_pkg, salc_ctrl, salc_dp (and salc_ram through salc_dp).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  req     | in  | req_tvalid/tready  | tdata: address[47:0]; tuser: cmd
//  rsp     | out | rsp_tvalid/tready  | tdata: prefetch_filled, 4 counters; tuser: hit
//  csr     | in  | csr_valid/ready    | csr_index (0..3), csr_data
//
// A request passes through capture + RAM read, demand lookup/write-back and result,
// and on a miss with prefetch on also a second set read and write-back. The set RAM,
// with one write port and its registered read, sets this sequence.
// Reset clears config to defaults, all valid bits and all counters.
// A finished result waits in the output register; a new request is taken while it
// waits, and the controller stalls only when a second result is ready.
module set_assoc_lru_cache_prefetch_core #(
   parameter int NumSets   = salc_pkg::NumSetsDefault,
   parameter int NumWays   = salc_pkg::NumWaysDefault,
   parameter int AddrWidth = salc_pkg::AddrWidthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [((AddrWidth+7)/8)*8-1:0]   req_tdata,   // address
   input  logic                             req_tuser,   // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // prefetch_filled, total_mem_reads, total_mem_writes, total_hits, total_misses
   output logic [135:0]                     rsp_tdata,
   output logic                             rsp_tuser,   // hit
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [salc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [3:0]                       csr_data
);
   salc_pkg::salc_cmd_type cmd;
   salc_pkg::salc_sts_type sts;
   logic                   pf_filled;
   logic [31:0]            c_reads, c_writes, c_hits, c_misses;

   assign csr_ready = 1'b1;

   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   salc_dp #(.NumSets(NumSets), .NumWays(NumWays), .AddrWidth(AddrWidth)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_cmd             (req_tuser),
      .req_address         (req_tdata[AddrWidth-1:0]),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_hit             (rsp_tuser),
      .rsp_prefetch_filled (pf_filled),
      .rsp_mem_reads       (c_reads),
      .rsp_mem_writes      (c_writes),
      .rsp_hits            (c_hits),
      .rsp_misses          (c_misses)
   );

   assign rsp_tdata = {7'd0, c_misses, c_hits, c_writes, c_reads, pf_filled};
endmodule

>>> dv/set_assoc_lru_cache_prefetch_core_tb.sv
// Testbench for set_assoc_lru_cache_prefetch_core: random and directed requests
// checked against a cache-state predictor. Depends on salc_pkg and the core RTL.
module set_assoc_lru_cache_prefetch_core_tb;

   localparam int Sets = 64;
   localparam int Ways = 4;

   typedef struct {
      bit        hit;
      bit        pf;
      bit [31:0] reads;
      bit [31:0] writes;
      bit [31:0] hits;
      bit [31:0] misses;
   } cache_rsp_type;

   // Cache tag state, counters and settings; predicts one response per request.
   class cache_scoreboard_type;
      bit            valid[Sets][Ways];
      bit [47:0]     tag[Sets][Ways];
      int            rank[Sets][Ways];
      bit [31:0]     reads, writes, hits, misses;
      int            ob = 6, sb = 6, nways = 4, pf_on = 0;
      cache_rsp_type pending[$];
      int            errors;

      function void set_reg(logic [salc_pkg::CsrIdxWidth-1:0] idx, bit [3:0] val);
         case (idx)
            salc_pkg::CSR_OFFSET_BITS: ob = val;
            salc_pkg::CSR_SET_BITS:    sb = val[2:0];
            salc_pkg::CSR_WAYS:        nways = val[2:0];
            salc_pkg::CSR_PREFETCH:    pf_on = val[0];
            default: ;
         endcase
      endfunction

      function int eff_ways();
         if (nways == 0) return 1;
         if (nways > Ways) return Ways;
         return nways;
      endfunction

      function int eff_sets();
         int b;
         b = sb;
         while (b > 0 && (1 << b) > Sets) b--;
         return b;
      endfunction

      function void make_recent(int s, int w, int old_rank, int nw);
         for (int v = 0; v < nw; v++) begin
            if (v != w && valid[s][v] && rank[s][v] < old_rank && rank[s][v] < nw - 1)
               rank[s][v]++;
         end
         rank[s][w] = 0;
      endfunction

      // returns 1 if the tag was already present
      function bit install(int s, bit [47:0] t, bit promote);
         int nw, victim, best;
         nw = eff_ways();
         victim = 0;
         best = 0;
         for (int v = 0; v < nw; v++) begin
            if (valid[s][v] && tag[s][v] == t) begin
               if (promote) make_recent(s, v, rank[s][v], nw);
               return 1;
            end
         end
         for (int v = 0; v < nw; v++) begin
            if (!valid[s][v]) begin
               valid[s][v] = 1;
               tag[s][v] = t;
               make_recent(s, v, nw, nw);
               return 0;
            end
         end
         // LRU victim: largest rank, highest index on ties
         for (int v = 0; v < nw; v++) begin
            if (rank[s][v] >= best) begin
               best = rank[s][v];
               victim = v;
            end
         end
         tag[s][victim] = t;
         make_recent(s, victim, rank[s][victim], nw);
         return 0;
      endfunction

      function void bump(ref bit [31:0] c);
         if (c != 32'hFFFF_FFFF) c++;
      endfunction

      function void note_request(bit cmd, bit [47:0] addr);
         int b, s;
         bit [47:0] t, na, m;
         cache_rsp_type r;
         b = eff_sets();
         m = 48'((1 << b) - 1);
         s = int'((addr >> ob) & m);
         t = addr >> (ob + b);
         r.hit = install(s, t, 1);
         r.pf = 0;
         if (cmd) bump(writes);
         if (r.hit) bump(hits);
         else begin
            bump(misses);
            bump(reads);
            if (pf_on) begin
               na = addr + (48'd1 << ob);   // wraps within 48 bits
               if (!install(int'((na >> ob) & m), na >> (ob + b), 0)) begin
                  r.pf = 1;
                  bump(reads);
               end
            end
         end
         r.reads = reads;
         r.writes = writes;
         r.hits = hits;
         r.misses = misses;
         pending.push_back(r);
      endfunction

      function void check_response(bit hit, logic [135:0] d);
         cache_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response, tuser=%0b tdata=%h", hit, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit);
            errors++;
         end
         if (d[0] !== e.pf) begin
            $error("prefetch_filled: expected %0d, got %0d", e.pf, d[0]);
            errors++;
         end
         if (d[32:1] !== e.reads) begin
            $error("total_mem_reads: expected %0d, got %0d", e.reads, d[32:1]);
            errors++;
         end
         if (d[64:33] !== e.writes) begin
            $error("total_mem_writes: expected %0d, got %0d", e.writes, d[64:33]);
            errors++;
         end
         if (d[96:65] !== e.hits) begin
            $error("total_hits: expected %0d, got %0d", e.hits, d[96:65]);
            errors++;
         end
         if (d[128:97] !== e.misses) begin
            $error("total_misses: expected %0d, got %0d", e.misses, d[128:97]);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             req_tvalid = 0;
   logic                             req_tready;
   logic [47:0]                      req_tdata = '0;
   logic                             req_tuser = 0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 0;
   logic [135:0]                     rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 0;
   logic                             csr_ready;
   logic [salc_pkg::CsrIdxWidth-1:0] csr_index = salc_pkg::CSR_OFFSET_BITS;
   logic [3:0]                       csr_data = '0;

   cache_scoreboard_type sb = new();
   bit                   calm = 0;        // no idling on either side while set
   bit [47:0]            hot_lines[12];

   set_assoc_lru_cache_prefetch_core u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   function int gap_len();
      int n;
      n = 0;
      if (!calm) while ($urandom_range(0, 99) < 31) n++;
      return n;
   endfunction

   // Response side: random backpressure; values read right after the edge are pre-edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
      rsp_tready <= calm || ($urandom_range(0, 99) >= 31);
   end

   // One request; tvalid stays high into the next call unless a gap is drawn.
   task send_request(bit cmd, bit [47:0] addr);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= addr;
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, addr);
   endtask

   task write_reg(logic [salc_pkg::CsrIdxWidth-1:0] idx, bit [3:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   // Let all outstanding responses drain, then let the pipeline settle.
   task drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task configure(bit [3:0] offs, bit [3:0] sets, bit [3:0] nw, bit [3:0] pf);
      write_reg(salc_pkg::CSR_OFFSET_BITS, offs);
      write_reg(salc_pkg::CSR_SET_BITS, sets);
      write_reg(salc_pkg::CSR_WAYS, nw);
      write_reg(salc_pkg::CSR_PREFETCH, pf);
      csr_valid <= 0;
   endtask

   function bit [47:0] pick_address();
      int k;
      bit [47:0] a;
      if ($urandom_range(0, 9) == 0) return 48'({$urandom, $urandom});
      k = $urandom_range(0, 11);
      // nearby blocks, same-set aliases and a random byte offset
      a = hot_lines[k] + (48'($urandom_range(0, 3)) << sb.ob)
          + (48'($urandom_range(0, 5)) << (sb.ob + sb.eff_sets()));
      a = a + (48'($urandom) & ((48'd1 << sb.ob) - 1));
      return a;
   endfunction

   task random_phase(int n);
      for (int i = 0; i < 12; i++) begin
         hot_lines[i] = 48'({$urandom, $urandom});
         if ($urandom_range(0, 7) == 0) hot_lines[i] = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 300);
      end
      for (int i = 0; i < n; i++) send_request(1'($urandom_range(0, 1)), pick_address());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed, at reset defaults: extremes, hits, and LRU eviction in one set.
      send_request(0, 48'h0);
      send_request(1, 48'h0);
      send_request(1, 48'hFFFF_FFFF_FFFF);
      send_request(0, 48'hFFFF_FFFF_FFC0);
      for (int i = 0; i < 5; i++) send_request(i[0], 48'(i) << 12);
      send_request(0, 48'h1000);   // recent, still present
      send_request(0, 48'h0);      // evicted
      send_request(1, 48'h2000);
      drain();

      // Direct mapped, fully associative, prefetch; wrap of the next-line address.
      configure(0, 0, 1, 1);
      send_request(0, 48'hFFFF_FFFF_FFFF);
      send_request(0, 48'h0);
      send_request(1, 48'h5);
      send_request(0, 48'h6);
      drain();
      configure(12, 7, 7, 1);     // set_bits clipped, ways clipped
      send_request(0, 48'hFFFF_FFFF_F000);
      send_request(1, 48'h0);
      send_request(0, 48'h1000);
      send_request(0, 48'h7FFFF);
      drain();

      random_phase(120);
      drain();
      configure(4, 3, 2, 1);
      random_phase(120);
      drain();
      configure(5, 2, 0, 0);      // ways 0 acts as direct mapped
      random_phase(120);
      drain();
      calm = 1;
      configure(6, 6, 4, 1);      // more ways again, stale ranks in play
      random_phase(120);
      drain();
      calm = 0;
      configure(3, 1, 3, 1);
      random_phase(120);
      drain();
      configure(0, 0, 4, 1);
      random_phase(115);
      drain();
      configure(12, 6, 4, 0);
      random_phase(115);
      drain();

      if (sb.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
